FILE: src/btlv_pkg.sv
// Shared types and constants for the BER TLV header parser.
// Depends on nothing; used by every module under src.
`timescale 1ns / 1ps

package btlv_pkg;

  localparam int TAG_BITS_DEF      = 28;
  localparam int MAX_LEN_BYTES_DEF = 4;

  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int CLASS_W   = 2;
  localparam int TAG_OUT_W = 28;
  localparam int LEN_W     = 32;
  localparam int ERR_W     = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_RESERVED   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INDEFINITE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LEN_LONG   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TAG_OVF    = 2'd3;

  // Identifier / length octet fields
  localparam logic [4:0] TAG_ESCAPE   = 5'h1f;
  localparam logic [6:0] LEN_RESERVED = 7'h7f;

  typedef enum logic [5:0] {
    PH_IDENT   = 6'b000001,
    PH_TAG     = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_LENLONG = 6'b001000,
    PH_VALUE   = 6'b010000,
    PH_DEAD    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [CLASS_W-1:0]   tag_class;
    logic                 constructed;
    logic [TAG_OUT_W-1:0] tag_num;
    logic [LEN_W-1:0]     content_length;
    logic [BYTE_W-1:0]    value_byte;
    logic                 last_value;
    logic [ERR_W-1:0]     error_code;
  } result_t;

  // Parser status seen by the top level
  typedef struct packed {
    logic dead;
    logic res_valid;
  } parse_stat_t;

endpackage

FILE: src/btlv_in_reg.sv
// Input register stage of the BER TLV header parser.
// Depends on btlv_pkg.
`timescale 1ns / 1ps

module btlv_in_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [btlv_pkg::BYTE_W-1:0]  in_byte,
  input  logic                         advance,
  output logic                         fire,
  output logic [btlv_pkg::BYTE_W-1:0]  byte_q
);

  logic                        valid_r, valid_nxt;
  logic [btlv_pkg::BYTE_W-1:0] byte_r;
  logic                        take;

  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;
  assign fire     = valid_r && advance;
  assign byte_q   = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

endmodule

FILE: src/btlv_parse.sv
// Parse state and single-pass decode of one byte into at most one result.
// Depends on btlv_pkg.
`timescale 1ns / 1ps

module btlv_parse #(
  parameter int TAG_BITS      = btlv_pkg::TAG_BITS_DEF,
  parameter int MAX_LEN_BYTES = btlv_pkg::MAX_LEN_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [btlv_pkg::BYTE_W-1:0]  byte_q,
  output btlv_pkg::result_t            result,
  output btlv_pkg::parse_stat_t        stat
);

  localparam int LCW = $clog2(MAX_LEN_BYTES + 1);

  btlv_pkg::phase_t                 phase_r, phase_nxt;
  logic [btlv_pkg::CLASS_W-1:0]     class_r, class_nxt;
  logic                             cons_r, cons_nxt;
  logic [TAG_BITS-1:0]              tag_r, tag_nxt;
  logic [btlv_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [LCW-1:0]                   lbytes_r, lbytes_nxt;
  logic [btlv_pkg::LEN_W-1:0]       vleft_r, vleft_nxt;

  logic [6:0]                       n;
  logic [btlv_pkg::LEN_W-1:0]       hdr_len;
  logic                             hdr_go;
  logic [btlv_pkg::LEN_W-1:0]       vdec;

  assign n    = byte_q[6:0];
  assign vdec = (vleft_r != '0) ? vleft_r - 1'b1 : vleft_r;

  always_comb begin
    phase_nxt  = phase_r;
    class_nxt  = class_r;
    cons_nxt   = cons_r;
    tag_nxt    = tag_r;
    len_nxt    = len_r;
    lbytes_nxt = lbytes_r;
    vleft_nxt  = vleft_r;
    result     = '0;
    stat       = '0;
    hdr_go     = 1'b0;
    hdr_len    = len_r;
    stat.dead  = (phase_r == btlv_pkg::PH_DEAD);

    case (phase_r)
      btlv_pkg::PH_IDENT: begin
        class_nxt = byte_q[7:6];
        cons_nxt  = byte_q[5];
        if (byte_q[4:0] != btlv_pkg::TAG_ESCAPE) begin
          tag_nxt   = TAG_BITS'(byte_q[4:0]);
          phase_nxt = btlv_pkg::PH_LEN;
        end else begin
          tag_nxt   = '0;
          phase_nxt = btlv_pkg::PH_TAG;
        end
      end
      btlv_pkg::PH_TAG: begin
        if (tag_r[TAG_BITS-1 -: 7] != '0) begin
          stat.res_valid    = 1'b1;
          result.kind       = btlv_pkg::KIND_ERROR;
          result.error_code = btlv_pkg::ERR_TAG_OVF;
          phase_nxt         = btlv_pkg::PH_DEAD;
        end else begin
          tag_nxt = (tag_r << 7) | TAG_BITS'(byte_q[6:0]);
          if (!byte_q[7]) begin
            phase_nxt = btlv_pkg::PH_LEN;
          end
        end
      end
      btlv_pkg::PH_LEN: begin
        if (!byte_q[7]) begin
          hdr_len = btlv_pkg::LEN_W'(byte_q);
          hdr_go  = 1'b1;
        end else if (n == btlv_pkg::LEN_RESERVED) begin
          stat.res_valid    = 1'b1;
          result.kind       = btlv_pkg::KIND_ERROR;
          result.error_code = btlv_pkg::ERR_RESERVED;
          phase_nxt         = btlv_pkg::PH_DEAD;
        end else if (n == 7'd0) begin
          stat.res_valid    = 1'b1;
          result.kind       = btlv_pkg::KIND_ERROR;
          result.error_code = btlv_pkg::ERR_INDEFINITE;
          phase_nxt         = btlv_pkg::PH_DEAD;
        end else if (n > 7'(MAX_LEN_BYTES)) begin
          stat.res_valid    = 1'b1;
          result.kind       = btlv_pkg::KIND_ERROR;
          result.error_code = btlv_pkg::ERR_LEN_LONG;
          phase_nxt         = btlv_pkg::PH_DEAD;
        end else begin
          len_nxt    = '0;
          lbytes_nxt = LCW'(n);
          phase_nxt  = btlv_pkg::PH_LENLONG;
        end
      end
      btlv_pkg::PH_LENLONG: begin
        hdr_len = {len_r[btlv_pkg::LEN_W-9:0], byte_q};
        len_nxt = hdr_len;
        if (lbytes_r != '0) begin
          lbytes_nxt = lbytes_r - 1'b1;
        end
        // Header completes once the count runs out
        if (lbytes_r <= LCW'(1)) begin
          hdr_go = 1'b1;
        end
      end
      btlv_pkg::PH_VALUE: begin
        stat.res_valid    = 1'b1;
        result.kind       = btlv_pkg::KIND_VALUE;
        result.value_byte = byte_q;
        result.last_value = (vleft_r <= btlv_pkg::LEN_W'(1));
        vleft_nxt         = vdec;
        if (vdec == '0) begin
          phase_nxt = btlv_pkg::PH_IDENT;
        end
      end
      default: begin
        phase_nxt = btlv_pkg::PH_DEAD;
      end
    endcase

    if (hdr_go) begin
      len_nxt               = hdr_len;
      stat.res_valid        = 1'b1;
      result.kind           = btlv_pkg::KIND_HEADER;
      result.tag_class      = class_r;
      result.constructed    = cons_r;
      result.tag_num        = btlv_pkg::TAG_OUT_W'(tag_r);
      result.content_length = hdr_len;
      if (cons_r || hdr_len == '0) begin
        phase_nxt = btlv_pkg::PH_IDENT;
      end else begin
        vleft_nxt = hdr_len;
        phase_nxt = btlv_pkg::PH_VALUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= btlv_pkg::PH_IDENT;
      class_r  <= '0;
      cons_r   <= 1'b0;
      tag_r    <= '0;
      len_r    <= '0;
      lbytes_r <= '0;
      vleft_r  <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      class_r  <= class_nxt;
      cons_r   <= cons_nxt;
      tag_r    <= tag_nxt;
      len_r    <= len_nxt;
      lbytes_r <= lbytes_nxt;
      vleft_r  <= vleft_nxt;
    end
  end

endmodule

FILE: src/btlv_out_reg.sv
// Result register of the BER TLV header parser; holds a transaction under stall.
// Depends on btlv_pkg.
`timescale 1ns / 1ps

module btlv_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic                  res_valid,
  input  btlv_pkg::result_t     result,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  advance,
  output btlv_pkg::result_t     result_q
);

  logic              valid_r, valid_nxt;
  btlv_pkg::result_t res_r;

  // Free to load when empty or being drained this cycle
  assign advance   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign result_q  = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

endmodule

FILE: src/ber_tlv_header_parser.sv
// BER TLV header parser: one byte per cycle when not stalled, at most one result per byte.
// An accepted byte goes through the input register, the decode and then the result register.
// Throughput: one byte every cycle when not stalled; decode is one pass over the phase state.
// Stall on the result side backs up through the input register to in_stall.
// Reset (rst_n low, synchronous) empties both registers and returns to expecting an
// identifier octet; after an error result the parser stays silent until reset.
`timescale 1ns / 1ps

module ber_tlv_header_parser #(
  parameter int TAG_BITS      = btlv_pkg::TAG_BITS_DEF,
  parameter int MAX_LEN_BYTES = btlv_pkg::MAX_LEN_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [btlv_pkg::BYTE_W-1:0]     in_byte_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [btlv_pkg::KIND_W-1:0]     out_kind,
  output logic [btlv_pkg::CLASS_W-1:0]    out_tag_class,
  output logic                            out_constructed,
  output logic [btlv_pkg::TAG_OUT_W-1:0]  out_tag_num,
  output logic [btlv_pkg::LEN_W-1:0]      out_content_length,
  output logic [btlv_pkg::BYTE_W-1:0]     out_value_byte,
  output logic                            out_last_value,
  output logic [btlv_pkg::ERR_W-1:0]      out_error_code
);

  logic                         advance;
  logic                         fire;
  logic [btlv_pkg::BYTE_W-1:0]  byte_q;
  btlv_pkg::result_t            result;
  btlv_pkg::result_t            result_q;
  btlv_pkg::parse_stat_t        stat;

  btlv_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte_in),
    .advance  (advance),
    .fire     (fire),
    .byte_q   (byte_q)
  );

  btlv_parse #(
    .TAG_BITS      (TAG_BITS),
    .MAX_LEN_BYTES (MAX_LEN_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .byte_q (byte_q),
    .result (result),
    .stat   (stat)
  );

  btlv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (stat.res_valid),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .advance   (advance),
    .result_q  (result_q)
  );

  assign out_kind           = result_q.kind;
  assign out_tag_class      = result_q.tag_class;
  assign out_constructed    = result_q.constructed;
  assign out_tag_num        = result_q.tag_num;
  assign out_content_length = result_q.content_length;
  assign out_value_byte     = result_q.value_byte;
  assign out_last_value     = result_q.last_value;
  assign out_error_code     = result_q.error_code;

  // Nothing follows a delivered error transaction
  a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind == btlv_pkg::KIND_ERROR |=> !out_valid)
    else $error("result delivered after error");

  // A byte consumed in the dead phase produces nothing
  a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    stat.dead && fire |=> !out_valid)
    else $error("result produced in dead phase");

  // A stalled output keeps the input side from consuming
  a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !fire)
    else $error("byte consumed while result stalled");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for ber_tlv_header_parser: directed octet table, random BER elements,
// and one closing error case, scored against listed tokens or an in-bench TLV decoder.
// Depends on btlv_pkg and the parser RTL under src.
`timescale 1ns / 1ps

module testbench;
  import btlv_pkg::*;

  localparam int ITEMS = 500;

  localparam logic [CLASS_W-1:0] CLS_UNIV = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_APPL = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_PRIV = 2'd3;

  localparam result_t NO_RES = '0;

  typedef struct {
    logic [BYTE_W-1:0] octet;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_byte_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    out_kind;
  logic [CLASS_W-1:0]   out_tag_class;
  logic                 out_constructed;
  logic [TAG_OUT_W-1:0] out_tag_num;
  logic [LEN_W-1:0]     out_content_length;
  logic [BYTE_W-1:0]    out_value_byte;
  logic                 out_last_value;
  logic [ERR_W-1:0]     out_error_code;

  // Decoder state, mirrors the parser between octets
  phase_t               dec_phase = PH_IDENT;
  logic [CLASS_W-1:0]   dec_class = '0;
  logic                 dec_cons = 1'b0;
  logic [TAG_OUT_W-1:0] dec_tag = '0;
  logic [LEN_W-1:0]     dec_len = '0;
  logic [2:0]           dec_len_left = '0;
  logic [LEN_W-1:0]     dec_val_left = '0;

  result_t           pending_tokens[$];
  logic [BYTE_W-1:0] element_octets[$];
  stim_row_t         dir_tab[26];
  bit                calm = 1'b0;
  int                hold_cnt = 0;
  int                n_bad = 0;

  ber_tlv_header_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_in         (in_byte_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_tag_class      (out_tag_class),
    .out_constructed    (out_constructed),
    .out_tag_num        (out_tag_num),
    .out_content_length (out_content_length),
    .out_value_byte     (out_value_byte),
    .out_last_value     (out_last_value),
    .out_error_code     (out_error_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic result_t hdr_res(input logic [CLASS_W-1:0] cls, input logic cons,
                                      input logic [TAG_OUT_W-1:0] tag,
                                      input logic [LEN_W-1:0] len);
    result_t r;
    r = '0;
    r.kind           = KIND_HEADER;
    r.tag_class      = cls;
    r.constructed    = cons;
    r.tag_num        = tag;
    r.content_length = len;
    return r;
  endfunction

  function automatic result_t val_res(input logic [BYTE_W-1:0] b, input logic last);
    result_t r;
    r = '0;
    r.kind       = KIND_VALUE;
    r.value_byte = b;
    r.last_value = last;
    return r;
  endfunction

  function automatic result_t err_res(input logic [ERR_W-1:0] code);
    result_t r;
    r = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  // Emit the header token and pick what the next octet means
  function automatic result_t close_header();
    result_t r;
    r = hdr_res(dec_class, dec_cons, dec_tag, dec_len);
    if (dec_cons || dec_len == '0) begin
      dec_phase = PH_IDENT;
    end else begin
      dec_val_left = dec_len;
      dec_phase    = PH_VALUE;
    end
    return r;
  endfunction

  // Advance the decoder by one octet; returns 1 when a token comes out
  function automatic bit decode_octet(input logic [BYTE_W-1:0] b, output result_t r);
    r = '0;
    case (dec_phase)
      PH_IDENT: begin
        dec_class = b[7:6];
        dec_cons  = b[5];
        if (b[4:0] != TAG_ESCAPE) begin
          dec_tag   = TAG_OUT_W'(b[4:0]);
          dec_phase = PH_LEN;
        end else begin
          dec_tag   = '0;
          dec_phase = PH_TAG;
        end
        return 1'b0;
      end
      PH_TAG: begin
        if ((dec_tag >> (TAG_BITS_DEF - 7)) != '0) begin
          r = err_res(ERR_TAG_OVF);
          dec_phase = PH_DEAD;
          return 1'b1;
        end
        dec_tag = {dec_tag[TAG_OUT_W-8:0], b[6:0]};
        if (!b[7]) dec_phase = PH_LEN;
        return 1'b0;
      end
      PH_LEN: begin
        if (!b[7]) begin
          dec_len = LEN_W'(b);
          r = close_header();
          return 1'b1;
        end
        if (b[6:0] == LEN_RESERVED) begin
          r = err_res(ERR_RESERVED);
        end else if (b[6:0] == 7'd0) begin
          r = err_res(ERR_INDEFINITE);
        end else if (b[6:0] > MAX_LEN_BYTES_DEF) begin
          r = err_res(ERR_LEN_LONG);
        end else begin
          dec_len      = '0;
          dec_len_left = b[2:0];
          dec_phase    = PH_LENLONG;
          return 1'b0;
        end
        dec_phase = PH_DEAD;
        return 1'b1;
      end
      PH_LENLONG: begin
        dec_len = {dec_len[LEN_W-9:0], b};
        if (dec_len_left != '0) dec_len_left--;
        if (dec_len_left == '0) begin
          r = close_header();
          return 1'b1;
        end
        return 1'b0;
      end
      PH_VALUE: begin
        r = val_res(b, dec_val_left <= 1);
        if (dec_val_left != '0) dec_val_left--;
        if (dec_val_left == '0) dec_phase = PH_IDENT;
        return 1'b1;
      end
      default: begin
        dec_phase = PH_DEAD;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string tok_str(input result_t r);
    return $sformatf("kind=%0d cls=%0d cons=%0d tag=%h len=%h val=%h last=%0d err=%0d",
                     r.kind, r.tag_class, r.constructed, r.tag_num,
                     r.content_length, r.value_byte, r.last_value, r.error_code);
  endfunction

  // Drive one octet, wait for the transaction, then record what it should produce
  task automatic send_octet(input logic [BYTE_W-1:0] b, input bit typed, input result_t want);
    int      gap;
    bit      has_tok;
    result_t tok;
    gap = calm ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall);
    has_tok = decode_octet(b, tok);
    if (typed) pending_tokens.push_back(want);
    else if (has_tok) pending_tokens.push_back(tok);
  endtask

  // Queue one well-formed element: identifier, tag, definite length, content
  task automatic build_element();
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  clen;
    bit                cons;
    int                ntag;
    int                nmin;
    int                nlen;
    cons  = ($urandom_range(0, 3) == 0);
    id    = BYTE_W'($urandom);
    id[5] = cons;
    if ($urandom_range(0, 2) == 0) id[4:0] = TAG_ESCAPE;
    element_octets.push_back(id);
    if (id[4:0] == TAG_ESCAPE) begin
      // a leading zero group keeps the tag value unchanged
      if ($urandom_range(0, 5) == 0) element_octets.push_back(8'h80);
      ntag = $urandom_range(1, 4);
      for (int k = ntag - 1; k >= 0; k--) begin
        b    = BYTE_W'($urandom);
        b[7] = (k != 0);
        element_octets.push_back(b);
      end
    end
    if (cons) clen = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
    else clen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    nmin = (clen > 32'h00FF_FFFF) ? 4 : (clen > 32'h0000_FFFF) ? 3 :
           (clen > 32'h0000_00FF) ? 2 : 1;
    if (clen < 128 && $urandom_range(0, 1) == 1) begin
      element_octets.push_back(BYTE_W'(clen));
    end else begin
      nlen = $urandom_range(nmin, MAX_LEN_BYTES_DEF);
      element_octets.push_back(8'h80 | BYTE_W'(nlen));
      for (int k = nlen - 1; k >= 0; k--) element_octets.push_back(BYTE_W'(clen >> (8 * k)));
    end
    if (!cons) repeat (clen) element_octets.push_back(BYTE_W'($urandom));
  endtask

  initial begin : stimulus
    int                sent;
    logic [ERR_W-1:0]  ecode;
    logic [BYTE_W-1:0] id;
    dir_tab = '{
      '{8'h40, 1'b0, NO_RES},
      '{8'h00, 1'b1, hdr_res(CLS_APPL, 1'b0, 28'd0, 32'd0)},
      '{8'hFE, 1'b0, NO_RES},
      '{8'h7F, 1'b1, hdr_res(CLS_PRIV, 1'b1, 28'd30, 32'd127)},
      '{8'h20, 1'b0, NO_RES},
      '{8'h84, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'hFF, 1'b1, hdr_res(CLS_UNIV, 1'b1, 28'd0, 32'hFFFF_FFFF)},
      '{8'hDF, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'h7F, 1'b0, NO_RES},
      '{8'h81, 1'b0, NO_RES},
      '{8'h02, 1'b1, hdr_res(CLS_PRIV, 1'b0, 28'hFFF_FFFF, 32'd2)},
      '{8'h00, 1'b1, val_res(8'h00, 1'b0)},
      '{8'hFF, 1'b1, val_res(8'hFF, 1'b1)},
      '{8'h9F, 1'b0, NO_RES},
      '{8'h80, 1'b0, NO_RES},
      '{8'h05, 1'b0, NO_RES},
      '{8'h82, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{8'h01, 1'b0, NO_RES},
      '{8'hA5, 1'b0, NO_RES}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_octet(dir_tab[i].octet, dir_tab[i].typed, dir_tab[i].want);

    sent = 0;
    while (sent < ITEMS) begin
      build_element();
      while (element_octets.size() != 0) begin
        send_octet(element_octets.pop_front(), 1'b0, NO_RES);
        sent++;
      end
    end

    // The parser dies on an error, so only one error case fits in a run
    ecode = ERR_W'($urandom_range(0, 3));
    id    = BYTE_W'($urandom);
    if (id[4:0] == TAG_ESCAPE) id[4:0] = 5'd0;
    case (ecode)
      ERR_TAG_OVF: begin
        id[4:0] = TAG_ESCAPE;
        send_octet(id, 1'b0, NO_RES);
        send_octet(8'h80 | BYTE_W'($urandom_range(1, 127)), 1'b0, NO_RES);
        repeat (3) send_octet(8'h80 | BYTE_W'($urandom), 1'b0, NO_RES);
        send_octet(BYTE_W'($urandom), 1'b1, err_res(ERR_TAG_OVF));
      end
      ERR_LEN_LONG: begin
        send_octet(id, 1'b0, NO_RES);
        send_octet(8'h80 | BYTE_W'($urandom_range(MAX_LEN_BYTES_DEF + 1, 126)), 1'b1,
                   err_res(ERR_LEN_LONG));
      end
      ERR_INDEFINITE: begin
        send_octet(id, 1'b0, NO_RES);
        send_octet(8'h80, 1'b1, err_res(ERR_INDEFINITE));
      end
      default: begin
        send_octet(id, 1'b0, NO_RES);
        send_octet(8'hFF, 1'b1, err_res(ERR_RESERVED));
      end
    endcase
    // Everything after the error must be dropped silently
    repeat ($urandom_range(8, 16)) send_octet(BYTE_W'($urandom), 1'b0, NO_RES);
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_bad == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_kind, out_tag_class, out_constructed, out_tag_num,
               out_content_length, out_value_byte, out_last_value, out_error_code};
        if (pending_tokens.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected token: %s", tok_str(got));
        end else begin
          want = pending_tokens.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("token mismatch: want %s", tok_str(want));
              $display("                got  %s", tok_str(got));
            end
          end
        end
        hold_cnt = calm ? 0 : $urandom_range(0, 19);
        out_stall <= (hold_cnt != 0);
      end else if (hold_cnt != 0) begin
        hold_cnt--;
        out_stall <= (hold_cnt != 0);
      end
    end
  end

endmodule

FILE: ber_tlv_header_parser.f
src/btlv_pkg.sv
src/btlv_in_reg.sv
src/btlv_parse.sv
src/btlv_out_reg.sv
src/ber_tlv_header_parser.sv
tb/sv/testbench.sv
